>>> hdl/ege_pkg.sv
// ege_pkg: shared types, constants and helpers of the density evaluator
// depends on nothing; imported by every module of the block
package ege_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PEAK_MEAN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_POINT = 2'd2;

    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [63:0] PROD_CAP  = 64'h4000_0000_0000_0000;
    localparam logic [31:0] OUT_MAX   = 32'hFFFF_FFFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // classified sample from the front end
    typedef struct packed {
        logic        tail;
        logic [32:0] diff;
    } ege_item_t;

    // values formed once per configuration change
    typedef struct packed {
        logic [63:0] inv_sigma;
        logic [63:0] beta_scaled;
        logic [63:0] const_off;
    } ege_derived_t;

    // saturate a product magnitude at 2^62
    function automatic logic [62:0] cap_mag(input logic [127:0] v);
        logic [62:0] res;
        if (v > {64'd0, PROD_CAP})
        begin
            res = PROD_CAP[62:0];
        end
        else
        begin
            res = v[62:0];
        end
        return res;
    endfunction

endpackage

>>> hdl/ege_cfg.sv
// ege_cfg: configuration registers and the sequencer that forms 1/sigma,
// beta and the tail offset with a bit-serial divider and a 32x32 multiplier
// depends on ege_pkg
module ege_cfg #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [ege_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ege_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [31:0]                        peak_mean,
    output logic [31:0]                        switch_point,
    output ege_pkg::ege_derived_t              derived,
    output logic                               busy
);
    import ege_pkg::*;

    localparam int QW = FRAC_BITS + 33;
    localparam int CNT_W = $clog2(QW);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_DIV     = 2'd1;
    localparam logic [1:0] ST_MUL_DN  = 2'd2;
    localparam logic [1:0] ST_MUL_OFF = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [31:0]      mean_reg, mean_next;
    logic [30:0]      width_reg, width_next;
    logic [31:0]      trans_reg, trans_next;
    logic [CNT_W-1:0] bit_reg, bit_next;
    logic [31:0]      rem_reg, rem_next;
    logic [63:0]      quot_reg, quot_next;
    logic [63:0]      ma_reg, ma_next;
    logic [63:0]      mb_reg, mb_next;
    logic [127:0]     acc_reg, acc_next;
    logic [1:0]       step_reg, step_next;
    logic             neg_reg, neg_next;
    logic [63:0]      inv_reg, inv_next;
    logic [63:0]      beta_reg, beta_next;
    logic [63:0]      off_reg, off_next;

    logic [31:0]  divisor;
    logic [31:0]  rem_sh;
    logic         qbit;
    logic [32:0]  mt_diff;
    logic [32:0]  mt_abs;
    logic [31:0]  ca, cb;
    logic [63:0]  pp;
    logic [1:0]   pos;
    logic [127:0] acc_sum;
    logic [62:0]  fin_mag;

    assign divisor = (width_reg == 31'd0) ? 32'd1 : {1'b0, width_reg};
    assign rem_sh  = {rem_reg[30:0], (bit_reg == CNT_W'(FRAC_BITS + 32))};
    assign qbit    = (rem_sh >= divisor);
    assign mt_diff = {mean_reg[31], mean_reg} - {trans_reg[31], trans_reg};
    assign mt_abs  = mt_diff[32] ? (33'd0 - mt_diff) : mt_diff;
    assign ca      = step_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
    assign cb      = step_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
    assign pp      = {32'd0, ca} * {32'd0, cb};
    assign pos     = {1'b0, step_reg[1]} + {1'b0, step_reg[0]};
    assign acc_sum = acc_reg + ({64'd0, pp} << {pos, 5'd0});

    always_comb
    begin
        state_next = state_reg;
        mean_next  = mean_reg;
        width_next = width_reg;
        trans_next = trans_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        acc_next   = acc_reg;
        step_next  = step_reg;
        neg_next   = neg_reg;
        inv_next   = inv_reg;
        beta_next  = beta_reg;
        off_next   = off_reg;
        fin_mag    = 63'd0;
        unique case (state_reg)
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                rem_next  = qbit ? (rem_sh - divisor) : rem_sh;
                quot_next = {quot_reg[62:0], qbit};
                bit_next  = bit_reg - CNT_W'(1);
                if (bit_reg == CNT_W'(0))
                begin
                    state_next = ST_MUL_DN;
                    inv_next   = quot_next;
                    ma_next    = {32'd0, mt_abs[31:0]};
                    mb_next    = quot_next;
                    neg_next   = mt_diff[32];
                    acc_next   = 128'd0;
                    step_next  = 2'd0;
                end
            end
            ST_MUL_DN:
            begin
                acc_next  = acc_sum;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    fin_mag    = cap_mag(acc_sum >> 32);
                    beta_next  = neg_reg ? (64'd0 - {1'b0, fin_mag}) : {1'b0, fin_mag};
                    ma_next    = {1'b0, fin_mag};
                    mb_next    = {1'b0, fin_mag};
                    acc_next   = 128'd0;
                    state_next = ST_MUL_OFF;
                end
            end
            ST_MUL_OFF:
            begin
                acc_next  = acc_sum;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    fin_mag    = cap_mag(acc_sum >> (FRAC_BITS + 1));
                    off_next   = 64'd0 - {1'b0, fin_mag};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // a write to a used register lands in any state and restarts the derivation
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PEAK_MEAN:    mean_next  = cfg_data;
                REG_PEAK_WIDTH:   width_next = cfg_data[30:0];
                REG_SWITCH_POINT: trans_next = cfg_data;
                default:          ;
            endcase
            if (cfg_index == REG_PEAK_MEAN || cfg_index == REG_PEAK_WIDTH ||
                cfg_index == REG_SWITCH_POINT)
            begin
                state_next = ST_DIV;
                bit_next   = CNT_W'(QW - 1);
                rem_next   = 32'd0;
                quot_next  = 64'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mean_reg  <= 32'd0;
            width_reg <= 31'd1 << FRAC_BITS;
            trans_reg <= 32'd0;
            inv_reg   <= 64'd1 << 32;
            beta_reg  <= 64'd0;
            off_reg   <= 64'd0;
            step_reg  <= 2'd0;
            bit_reg   <= CNT_W'(0);
        end
        else
        begin
            state_reg <= state_next;
            mean_reg  <= mean_next;
            width_reg <= width_next;
            trans_reg <= trans_next;
            inv_reg   <= inv_next;
            beta_reg  <= beta_next;
            off_reg   <= off_next;
            step_reg  <= step_next;
            bit_reg   <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        acc_reg  <= acc_next;
        neg_reg  <= neg_next;
    end

    assign peak_mean    = mean_reg;
    assign switch_point = trans_reg;
    assign derived      = '{inv_sigma: inv_reg, beta_scaled: beta_reg, const_off: off_reg};
    assign busy         = (state_reg != ST_IDLE);

endmodule

>>> hdl/ege_front.sv
// ege_front: input register that picks the branch and forms x - mean or x - trans
// depends on ege_pkg
module ege_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [31:0]           sample_value,
    input  logic [31:0]           peak_mean,
    input  logic [31:0]           switch_point,
    input  logic                  busy,
    output logic                  push_valid,
    input  logic                  push_ready,
    output ege_pkg::ege_item_t    push_item
);
    import ege_pkg::*;

    logic      fr_valid_reg, fr_valid_next;
    ege_item_t fr_item_reg;
    ege_item_t item_new;
    logic      take;
    logic [31:0] ref_val;

    assign in_ready = !busy && (!fr_valid_reg || push_ready);
    assign take     = in_valid && in_ready;

    always_comb
    begin
        item_new.tail = ($signed(sample_value) <= $signed(switch_point));
        ref_val       = item_new.tail ? switch_point : peak_mean;
        item_new.diff = {sample_value[31], sample_value} - {ref_val[31], ref_val};
    end

    always_comb
    begin
        fr_valid_next = fr_valid_reg;
        if (take)
        begin
            fr_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            fr_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            fr_item_reg <= item_new;
        end
    end

    assign push_valid = fr_valid_reg;
    assign push_item  = fr_item_reg;

endmodule

>>> hdl/ege_queue.sv
// ege_queue: short register queue between the front end and the arithmetic pipeline
// depends on ege_pkg
module ege_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  ege_pkg::ege_item_t push_item,
    output logic               pop_valid,
    input  logic               pop,
    output ege_pkg::ege_item_t pop_item
);
    import ege_pkg::*;

    ege_item_t           slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW + 1)'(do_push) - (QUEUE_AW + 1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hdl/ege_back.sv
// ege_back: twelve-stage arithmetic pipeline plus output register, argument
// products, base-2 split, table and polynomial, final scaling and saturation
// depends on ege_pkg
module ege_back #(
    parameter int FRAC_BITS = 16,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_take,
    input  ege_pkg::ege_item_t    item,
    input  ege_pkg::ege_derived_t derived,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           density_value,
    output logic                  on_tail_side,
    output logic                  clipped
);
    import ege_pkg::*;

    localparam int STAGES = 12;
    localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
    localparam int RECIP_SH = 30 + IDX_W;
    localparam logic [63:0] RECIP_WIDE = (64'd1 << RECIP_SH) / EXP_TABLE_DEPTH;
    localparam logic [31:0] RECIP = RECIP_WIDE[31:0];
    localparam logic [IDX_W+29:0] DEPTH_POS = (IDX_W + 30)'(EXP_TABLE_DEPTH);
    localparam logic [29:0] DEPTH_Q = 30'(EXP_TABLE_DEPTH);
    localparam logic [63:0] Y_TOP = 64'(32 - FRAC_BITS) << FRAC_BITS;
    localparam logic [63:0] Y_BIAS = 64'(FRAC_BITS + 2) << FRAC_BITS;

    // 2^(i/D) in Q.30 by a truncating Taylor series
    function automatic logic [31:0] pow2_entry(input int unsigned idx);
        logic [63:0] x;
        logic [63:0] sum;
        logic [63:0] term;
        x    = (64'(idx) * 64'(LN2_Q30)) / EXP_TABLE_DEPTH;
        sum  = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int k = 1; k < 40; k++)
        begin
            if (term != 64'd0)
            begin
                term = ((term * x) >> 30) / 64'(k);
                sum  = sum + term;
            end
        end
        return sum[31:0];
    endfunction

    logic [31:0] pow2_tab [EXP_TABLE_DEPTH];

    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++)
    begin : g_tab
        assign pow2_tab[g] = pow2_entry(g);
    end

    logic              adv;
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] tail_reg;
    logic              out_valid_reg;

    assign adv       = !out_valid_reg || out_ready;
    assign item_take = adv && item_valid;

    // stage registers
    logic        s1_neg_reg;
    logic [63:0] s1_lo_reg, s1_hi_reg;
    logic        s2_neg_reg;
    logic [62:0] s2_mag_reg;
    logic        s3_neg_reg;
    logic [63:0] s3_p00_reg, s3_p01_reg, s3_p10_reg, s3_p11_reg;
    logic        s4_neg_reg;
    logic [62:0] s4_mag_reg;
    logic [63:0] s5_arg_reg;
    logic        s6_neg_reg;
    logic [63:0] s6_p0_reg, s6_p1_reg;
    logic [63:0] s7_y_reg;
    logic        s8_hi_reg, s8_lo_reg;
    logic [5:0]  s8_zi_reg;
    logic [IDX_W-1:0] s8_idx_reg;
    logic [29:0] s8_rem_reg;
    logic        s9_hi_reg, s9_lo_reg;
    logic [5:0]  s9_zi_reg;
    logic [29:0] s9_v_reg;
    logic [31:0] s9_t_reg;
    logic        s10_hi_reg, s10_lo_reg;
    logic [5:0]  s10_zi_reg;
    logic [29:0] s10_v_reg, s10_q_reg;
    logic [31:0] s10_t_reg;
    logic        s11_hi_reg, s11_lo_reg;
    logic [5:0]  s11_zi_reg;
    logic [29:0] s11_c_reg;
    logic [31:0] s11_t_reg;
    logic        s12_hi_reg, s12_lo_reg;
    logic [5:0]  s12_zi_reg;
    logic [31:0] s12_m_reg;
    logic [31:0] dens_reg;
    logic        tail_out_reg, clip_reg;

    // combinational per stage
    logic [32:0]  d_abs;
    logic [95:0]  p96;
    logic         dn_neg;
    logic [63:0]  dn_abs;
    logic [62:0]  op_b;
    logic [127:0] p128;
    logic [127:0] p128_sh;
    logic [63:0]  r5;
    logic [63:0]  arg_next;
    logic         a_neg;
    logic [63:0]  a_mag;
    logic [95:0]  py;
    logic [62:0]  y_mag;
    logic [63:0]  z;
    logic [FRAC_BITS-1:0] frac;
    logic [29:0]  fq;
    logic [IDX_W+29:0] pos;
    logic [59:0]  vprod;
    logic [63:0]  qprod;
    logic [63:0]  qd;
    logic [29:0]  rr;
    logic [63:0]  tc;
    logic [33:0]  sh_val;
    logic [34:0]  rnd;
    logic [33:0]  r_fin;
    logic [31:0]  dens_next;
    logic         clip_next;

    always_comb
    begin
        d_abs   = item.diff[32] ? (33'd0 - item.diff) : item.diff;
        p96     = {32'd0, s1_lo_reg} + {s1_hi_reg, 32'd0};
        dn_neg  = derived.beta_scaled[63];
        dn_abs  = dn_neg ? (64'd0 - derived.beta_scaled) : derived.beta_scaled;
        op_b    = tail_reg[1] ? dn_abs[62:0] : s2_mag_reg;
        p128    = {64'd0, s3_p00_reg} + {32'd0, s3_p01_reg, 32'd0}
                + {32'd0, s3_p10_reg, 32'd0} + {s3_p11_reg, 64'd0};
        p128_sh = tail_reg[2] ? (p128 >> FRAC_BITS) : (p128 >> (FRAC_BITS + 1));
        r5      = {1'b0, s4_mag_reg};
        if (tail_reg[3])
        begin
            arg_next = s4_neg_reg ? (derived.const_off - r5) : (derived.const_off + r5);
        end
        else
        begin
            arg_next = 64'd0 - r5;
        end
        a_neg   = s5_arg_reg[63];
        a_mag   = a_neg ? (64'd0 - s5_arg_reg) : s5_arg_reg;
        py      = {32'd0, s6_p0_reg} + {s6_p1_reg, 32'd0};
        y_mag   = cap_mag({32'd0, py} >> 30);
        z       = s7_y_reg + Y_BIAS;
        frac    = z[FRAC_BITS-1:0];
        fq      = 30'(frac) << (30 - FRAC_BITS);
        pos     = (IDX_W + 30)'(fq) * DEPTH_POS;
        vprod   = {30'd0, s8_rem_reg} * {30'd0, LN2_Q30};
        qprod   = {34'd0, s9_v_reg} * {32'd0, RECIP};
        qd      = {34'd0, s10_q_reg} * {34'd0, DEPTH_Q};
        rr      = 30'({34'd0, s10_v_reg} - qd);
        tc      = {32'd0, s11_t_reg} * {34'd0, s11_c_reg};
        sh_val  = {s12_m_reg, 2'b00} >> (6'd33 - s12_zi_reg);
        rnd     = {1'b0, sh_val} + 35'd1;
        r_fin   = rnd[34:1];
        if (s12_hi_reg)
        begin
            dens_next = OUT_MAX;
            clip_next = 1'b1;
        end
        else if (s12_lo_reg)
        begin
            dens_next = 32'd0;
            clip_next = 1'b0;
        end
        else if (r_fin > {2'b00, OUT_MAX})
        begin
            dens_next = OUT_MAX;
            clip_next = 1'b1;
        end
        else
        begin
            dens_next = r_fin[31:0];
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[STAGES-2:0], item_take};
            out_valid_reg <= vld_reg[STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tail_reg   <= {tail_reg[STAGES-2:0], item.tail};
            // x - ref times 1/sigma
            s1_neg_reg <= item.diff[32];
            s1_lo_reg  <= {32'd0, d_abs[31:0]} * {32'd0, derived.inv_sigma[31:0]};
            s1_hi_reg  <= {32'd0, d_abs[31:0]} * {32'd0, derived.inv_sigma[63:32]};
            s2_neg_reg <= s1_neg_reg;
            s2_mag_reg <= cap_mag({64'd0, p96[95:32]});
            // square or product with beta
            s3_neg_reg <= tail_reg[1] && (s2_neg_reg ^ dn_neg);
            s3_p00_reg <= {32'd0, s2_mag_reg[31:0]} * {32'd0, op_b[31:0]};
            s3_p01_reg <= {32'd0, s2_mag_reg[31:0]} * {33'd0, op_b[62:32]};
            s3_p10_reg <= {33'd0, s2_mag_reg[62:32]} * {32'd0, op_b[31:0]};
            s3_p11_reg <= {33'd0, s2_mag_reg[62:32]} * {33'd0, op_b[62:32]};
            s4_neg_reg <= s3_neg_reg;
            s4_mag_reg <= cap_mag(p128_sh);
            s5_arg_reg <= arg_next;
            // times log2(e)
            s6_neg_reg <= a_neg;
            s6_p0_reg  <= {32'd0, a_mag[31:0]} * {33'd0, LOG2E_Q30};
            s6_p1_reg  <= {32'd0, a_mag[63:32]} * {33'd0, LOG2E_Q30};
            s7_y_reg   <= s6_neg_reg ? (64'd0 - {1'b0, y_mag}) : {1'b0, y_mag};
            // integer and fraction split
            s8_hi_reg  <= ($signed(s7_y_reg) >= $signed(Y_TOP));
            s8_lo_reg  <= ($signed(s7_y_reg) < $signed(64'd0 - Y_BIAS));
            s8_zi_reg  <= z[FRAC_BITS +: 6];
            s8_idx_reg <= pos[30 +: IDX_W];
            s8_rem_reg <= pos[29:0];
            // table lookup and interpolation step
            s9_hi_reg  <= s8_hi_reg;
            s9_lo_reg  <= s8_lo_reg;
            s9_zi_reg  <= s8_zi_reg;
            s9_v_reg   <= vprod[59:30];
            s9_t_reg   <= pow2_tab[s8_idx_reg];
            s10_hi_reg <= s9_hi_reg;
            s10_lo_reg <= s9_lo_reg;
            s10_zi_reg <= s9_zi_reg;
            s10_v_reg  <= s9_v_reg;
            s10_q_reg  <= 30'(qprod >> RECIP_SH);
            s10_t_reg  <= s9_t_reg;
            s11_hi_reg <= s10_hi_reg;
            s11_lo_reg <= s10_lo_reg;
            s11_zi_reg <= s10_zi_reg;
            s11_c_reg  <= (rr >= DEPTH_Q) ? (s10_q_reg + 30'd1) : s10_q_reg;
            s11_t_reg  <= s10_t_reg;
            s12_hi_reg <= s11_hi_reg;
            s12_lo_reg <= s11_lo_reg;
            s12_zi_reg <= s11_zi_reg;
            s12_m_reg  <= s11_t_reg + 32'(tc >> 30);
            // output register
            dens_reg     <= dens_next;
            clip_reg     <= clip_next;
            tail_out_reg <= tail_reg[STAGES-1];
        end
    end

    assign out_valid     = out_valid_reg;
    assign density_value = dens_reg;
    assign on_tail_side  = tail_out_reg;
    assign clipped       = clip_reg;

endmodule

>>> hdl/exp_gauss_density_eval_top.sv
// exp_gauss_density_eval_top: gaussian density with exponential tail, Q16.16
// depends on ege_pkg, ege_cfg, ege_front, ege_queue, ege_back
//
// channel  | signals                                        | handshake
// ---------+------------------------------------------------+-----------------
// input    | sample_value                                   | in_valid/in_ready
// output   | density_value, on_tail_side, clipped           | out_valid/out_ready
// config   | cfg_index, cfg_data                            | cfg_write
//
// one item per cycle while in_ready is high; an accepted item reaches out_valid through
// the front register, queue, twelve arithmetic stages and output register
// a register write recomputes 1/sigma, beta and offset with the one-bit-a-cycle divider
// and the four-step multiplier; in_ready is low while that runs
// reset loads the derived values of the reset registers directly, no extra pass
// an output stall freezes the pipeline; the front and its 4-entry queue keep taking items until full
module exp_gauss_density_eval_top #(
    parameter int FRAC_BITS = 16,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [31:0]                        sample_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [31:0]                        density_value,
    output logic                               on_tail_side,
    output logic                               clipped,
    input  logic                               cfg_write,
    input  logic [ege_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ege_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ege_pkg::*;

    logic [31:0]  peak_mean;
    logic [31:0]  switch_point;
    ege_derived_t derived;
    logic         busy;
    logic         push_valid, push_ready;
    ege_item_t    push_item;
    logic         pop_valid, pop;
    ege_item_t    pop_item;

    ege_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .peak_mean    (peak_mean),
        .switch_point (switch_point),
        .derived      (derived),
        .busy         (busy)
    );

    ege_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_value (sample_value),
        .peak_mean    (peak_mean),
        .switch_point (switch_point),
        .busy         (busy),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_item    (push_item)
    );

    ege_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_item   (pop_item)
    );

    ege_back #(
        .FRAC_BITS       (FRAC_BITS),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (pop_valid),
        .item_take     (pop),
        .item          (pop_item),
        .derived       (derived),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .density_value (density_value),
        .on_tail_side  (on_tail_side),
        .clipped       (clipped)
    );

endmodule

>>> sim/tb.sv
// tb: self-checking bench for exp_gauss_density_eval_top, random and directed samples
// depends on ege_pkg and the rtl under hdl; holds its own bit-exact density predictor
`timescale 1ns / 100ps

module tb;
    import ege_pkg::*;

    localparam int FRAC = 16;
    localparam int DEPTH = 256;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [31:0] value;
        logic        tail;
        logic        clip;
    } density_t;

    class density_tracker;
        longint      mean_q;
        longint      width_q;
        longint      switch_q;
        longint      inv_sigma;
        longint      beta_q;
        longint      offset_q;
        logic [63:0] pow2_q30 [DEPTH];
        density_t    pending[$];
        int          mismatches;
        int          results_seen;

        function new();
            logic [63:0] x, acc, term;
            for (int i = 0; i < DEPTH; i++)
            begin
                x = (64'(i) * 64'(LN2_Q30)) / DEPTH;
                acc = 64'd1 << 30;
                term = 64'd1 << 30;
                for (int k = 1; k < 40 && term != 0; k++)
                begin
                    term = ((term * x) >> 30) / k;
                    acc += term;
                end
                pow2_q30[i] = acc;
            end
            mean_q = 0;
            width_q = 64'd1 << FRAC;
            switch_q = 0;
            mismatches = 0;
            results_seen = 0;
            rederive();
        endfunction

        function longint scaled_mul(longint a, longint b, int sh);
            logic [63:0]  ua, ub;
            logic [127:0] p;
            logic         neg;
            neg = (a < 0) != (b < 0);
            ua = a < 0 ? 64'(-a) : 64'(a);
            ub = b < 0 ? 64'(-b) : 64'(b);
            p = {64'd0, ua} * {64'd0, ub};
            p = p >> sh;
            if (p > {64'd0, PROD_CAP})
                p = {64'd0, PROD_CAP};
            return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
        endfunction

        function void rederive();
            logic [63:0] s;
            s = width_q == 0 ? 64'd1 : 64'(width_q);
            inv_sigma = longint'((64'd1 << (FRAC + 32)) / s);
            beta_q = scaled_mul(mean_q - switch_q, inv_sigma, 32);
            offset_q = -scaled_mul(beta_q, beta_q, FRAC + 1);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            if (idx == REG_PEAK_MEAN)
                mean_q = longint'(signed'(data));
            else if (idx == REG_PEAK_WIDTH)
                width_q = longint'({33'd0, data[30:0]});
            else if (idx == REG_SWITCH_POINT)
                switch_q = longint'(signed'(data));
            else
                return;
            rederive();
        endfunction

        function density_t fixed_exp(longint arg);
            density_t    d;
            longint      y, top, bias;
            logic [63:0] z, fq, pos, idx, rem, corr, t, m, r;
            int          n, s;
            top = longint'(32 - FRAC) << FRAC;
            bias = longint'(FRAC + 2) << FRAC;
            y = scaled_mul(arg, longint'(LOG2E_Q30), 30);
            d.clip = 1'b0;
            d.value = 32'd0;
            if (y >= top)
            begin
                d.clip = 1'b1;
                d.value = OUT_MAX;
                return d;
            end
            if (y < -bias)
                return d;
            z = 64'(y + bias);
            n = int'(z >> FRAC) - (FRAC + 2);
            fq = (z & ((64'd1 << FRAC) - 1)) << (30 - FRAC);
            pos = fq * DEPTH;
            idx = pos >> 30;
            rem = pos & ((64'd1 << 30) - 1);
            corr = ((rem * 64'(LN2_Q30)) >> 30) / DEPTH;
            t = pow2_q30[idx < DEPTH ? idx : DEPTH - 1];
            m = t + ((t * corr) >> 30);
            s = n + FRAC - 30;
            if (s >= 0)
                r = m << s;
            else
                r = (m + (64'd1 << (-s - 1))) >> (-s);
            if (r > 64'(OUT_MAX))
            begin
                d.clip = 1'b1;
                d.value = OUT_MAX;
            end
            else
                d.value = r[31:0];
            return d;
        endfunction

        function void note_sample(logic [31:0] raw);
            longint   x, arg, w, u;
            logic     tail;
            density_t d;
            x = longint'(signed'(raw));
            tail = x <= switch_q;
            if (tail)
            begin
                w = scaled_mul(x - switch_q, inv_sigma, 32);
                arg = scaled_mul(w, beta_q, FRAC) + offset_q;
            end
            else
            begin
                u = scaled_mul(x - mean_q, inv_sigma, 32);
                arg = -scaled_mul(u, u, FRAC + 1);
            end
            d = fixed_exp(arg);
            d.tail = tail;
            pending.push_back(d);
        endfunction

        function void check_density(logic [31:0] value, logic tail, logic clip);
            density_t e;
            results_seen++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: density %h tail %b clip %b", value, tail, clip);
                return;
            end
            e = pending.pop_front();
            if (e.value !== value || e.tail !== tail || e.clip !== clip)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected density %h tail %b clip %b, got %h %b %b",
                             e.value, e.tail, e.clip, value, tail, clip);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [31:0]           sample_value;
    logic                  out_valid;
    logic                  out_ready;
    logic [31:0]           density_value;
    logic                  on_tail_side;
    logic                  clipped;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    density_tracker tracker;
    int             send_idle_pct;
    int             stall_pct;
    int             cycle_count;
    int             items_sent;
    int             reg_writes;
    longint         cur_mean;
    longint         cur_width;
    longint         cur_switch;

    exp_gauss_density_eval_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_value  (sample_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .density_value (density_value),
        .on_tail_side  (on_tail_side),
        .clipped       (clipped),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        if (rst_n)
        begin
            if (in_valid && in_ready)
                tracker.note_sample(sample_value);
            if (out_valid && out_ready)
                tracker.check_density(density_value, on_tail_side, clipped);
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_sample(input logic [31:0] v);
        in_valid <= 1'b1;
        sample_value <= v;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            sample_value <= $urandom;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        tracker.write_reg(idx, data);
        if (idx == REG_PEAK_MEAN)
            cur_mean = longint'(signed'(data));
        else if (idx == REG_PEAK_WIDTH)
            cur_width = longint'({33'd0, data[30:0]});
        else if (idx == REG_SWITCH_POINT)
            cur_switch = longint'(signed'(data));
        reg_writes++;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_shape(input logic [31:0] m, input logic [31:0] w, input logic [31:0] s);
        write_reg(REG_PEAK_MEAN, m);
        write_reg(REG_PEAK_WIDTH, w);
        write_reg(REG_SWITCH_POINT, s);
    endtask

    function automatic logic [31:0] pick_sample();
        longint span;
        span = cur_width == 0 ? 1 : cur_width;
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'(cur_mean + (int'($urandom_range(800)) - 400) * span / 100);
            2: return 32'(cur_switch + (int'($urandom_range(400)) - 200) * span / 100);
            3: return 32'(cur_switch + int'($urandom_range(4)) - 2);
            default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    task automatic random_shape();
        logic [31:0] m, w, s;
        case ($urandom_range(5))
            0: w = 32'd1;
            1: w = 32'd0;
            2: w = 32'h7FFF_FFFF;
            3: w = 32'h0001_0000;
            default: w = $urandom_range(32'h0008_0000, 32'h0000_0100);
        endcase
        case ($urandom_range(4))
            0: m = 32'h8000_0000;
            1: m = 32'h7FFF_FFFF;
            2: m = $urandom;
            default: m = 32'($urandom_range(20 << 16)) - 32'(10 << 16);
        endcase
        case ($urandom_range(3))
            0: s = $urandom;
            1: s = m + 32'($urandom_range(6) * w) - 32'(3 * w);
            default: s = m - 32'($urandom_range(3) * w) - 32'($urandom_range(16'hFFFF));
        endcase
        if ($urandom_range(9) == 0)
            write_reg(REG_UNUSED, $urandom);
        set_shape(m, w, s);
    endtask

    initial
    begin
        tracker = new();
        cycle_count = 0;
        items_sent = 0;
        reg_writes = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        cur_mean = 0;
        cur_width = 64'd1 << FRAC;
        cur_switch = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample_value = 32'd0;
        out_ready = 1'b1;
        cfg_write = 1'b0;
        cfg_index = REG_PEAK_MEAN;
        cfg_data = 32'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset shape: peak, extremes, both sides of the switch point
        send_sample(32'h0000_0000);
        send_sample(32'h0000_0001);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h0001_0000);
        send_sample(32'hFFFF_0000);
        send_sample(32'h0005_0000);
        send_sample(32'hFFFB_0000);
        drain();

        // zero sigma acts as the smallest step; unknown index ignored
        write_reg(REG_UNUSED, 32'h1234_5678);
        set_shape(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        send_sample(32'h0000_0000);
        send_sample(32'h0000_0001);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'hFFFF_FFFE);
        drain();

        // tail grows when the mean sits below the switch point: saturation
        set_shape(32'hFFF6_0000, 32'h0000_8000, 32'h000A_0000);
        send_sample(32'h000A_0000);
        send_sample(32'h0009_8000);
        send_sample(32'hFFF6_0000);
        send_sample(32'h8000_0000);
        drain();

        // huge products and deep underflow
        set_shape(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h0000_0000);
        drain();
        set_shape(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h8000_0001);
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 84; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 84; end
                default: begin send_idle_pct = 23; stall_pct = 23; end
            endcase
            random_shape();
            for (int i = 0; i < 58; i++)
            begin
                send_sample(pick_sample());
                if (ph == 5 && i == 29)
                    drain();
            end
            drain();
        end
        stall_pct = 0;
        repeat (40) @(posedge clk);

        $display("covered %0d samples over %0d register writes, four idle/stall patterns",
                 items_sent, reg_writes);
        $display("%0d results checked, %0d still outstanding",
                 tracker.results_seen, tracker.pending.size());
        if (tracker.mismatches == 0 && tracker.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
hdl/ege_pkg.sv
hdl/ege_cfg.sv
hdl/ege_front.sv
hdl/ege_queue.sv
hdl/ege_back.sv
hdl/exp_gauss_density_eval_top.sv
sim/tb.sv
